/* src/rru_pkg.sv */
package rru_pkg;

  // sizes of the register files
  localparam int unsigned PHYS_REGS = 32;
  localparam int unsigned ARCH_REGS = 16;
  localparam int unsigned PHYS_IDX_W = (PHYS_REGS > 1) ? $clog2(PHYS_REGS) : 1;
  localparam int unsigned ARCH_IDX_W = (ARCH_REGS > 1) ? $clog2(ARCH_REGS) : 1;

  // field widths on the channels
  localparam int unsigned OP_W   = 3;
  localparam int unsigned ARCH_W = 4;
  localparam int unsigned PHYS_W = 5;
  localparam int unsigned DATA_W = 32;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_ALLOC     = 3'd0,
    OP_LOOKUP    = 3'd1,
    OP_READ      = 3'd2,
    OP_WRITEBACK = 3'd3,
    OP_COMMIT    = 3'd4
  } op_e;

  // one rename table entry
  typedef struct packed {
    logic                  valid;
    logic [PHYS_IDX_W-1:0] num;
  } map_t;

  // operation held between input and result registers
  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic [ARCH_W-1:0]        arch_reg;
    logic [PHYS_W-1:0]        phys_reg;
    logic signed [DATA_W-1:0] write_value;
  } req_t;

  // result of one operation
  typedef struct packed {
    logic                     ok;
    logic [PHYS_W-1:0]        phys_out;
    logic signed [DATA_W-1:0] read_value;
  } rsp_t;

endpackage

/* src/rru_req_if.sv */
interface rru_req_if;
  logic                                       valid;
  logic                                       ready;
  logic [rru_pkg::OP_W-1:0]                   op;
  logic [rru_pkg::ARCH_W-1:0]                 arch_reg;
  logic [rru_pkg::PHYS_W-1:0]                 phys_reg;
  logic signed [rru_pkg::DATA_W-1:0]          write_value;

  modport source (output valid, op, arch_reg, phys_reg, write_value, input ready);
  modport sink (input valid, op, arch_reg, phys_reg, write_value, output ready);
endinterface

/* src/rru_rsp_if.sv */
interface rru_rsp_if;
  logic                                       valid;
  logic                                       ready;
  logic                                       ok;
  logic [rru_pkg::PHYS_W-1:0]                 phys_out;
  logic signed [rru_pkg::DATA_W-1:0]          read_value;

  modport source (output valid, ok, phys_out, read_value, input ready);
  modport sink (input valid, ok, phys_out, read_value, output ready);
endinterface

/* src/register_rename_unit.sv */
// register rename unit with a unified physical register file
// req_i carries one operation per transaction: allocate, lookup, read,
// writeback or commit, with its architectural and physical register numbers
// and a writeback value. rsp_o returns exactly one result per operation,
// in order: an ok flag, a physical register number and a read value.
// an operation accepted at a clock edge is captured in the input register,
// executed against the tables from there and lands in the result register
// when it advances. throughput is one operation per cycle while rsp_o
// does not stall; the free-register search is a single priority encoder
// over the allocation bits, done combinationally in the execute stage.
// when rsp_o stalls, the result register holds and the input register keeps
// the next operation, so req_i drops ready only when both are full.
// reset (rst_ni low) frees every physical register, clears all ready bits
// and unmaps both rename tables; register values need no reset since a read
// only returns a value after a writeback has marked it ready.
module register_rename_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  rru_req_if.sink          req_i,
  rru_rsp_if.source        rsp_o
);

  localparam int unsigned PR = rru_pkg::PHYS_REGS;
  localparam int unsigned AR = rru_pkg::ARCH_REGS;
  localparam int unsigned PIW = rru_pkg::PHYS_IDX_W;
  localparam int unsigned AIW = rru_pkg::ARCH_IDX_W;

  // pipeline registers
  logic          s1_valid_q, s1_valid_d;
  rru_pkg::req_t s1_req_q;
  logic          rsp_valid_q, rsp_valid_d;
  rru_pkg::rsp_t rsp_q, rsp_d;
  logic          in_fire, adv;

  // state
  logic [PR-1:0]                         alloc_q;
  logic [PR-1:0]                         ready_q;
  logic signed [rru_pkg::DATA_W-1:0]     values_q [PR];
  rru_pkg::map_t                         spec_q [AR];
  rru_pkg::map_t                         commit_q [AR];

  // execute stage signals
  logic            a_ok, p_ok;
  logic [AIW-1:0]  a_idx;
  logic [PIW-1:0]  p_idx;
  logic            free_found;
  logic [PIW-1:0]  free_idx;
  logic            do_alloc, do_wb, do_commit, do_free;
  rru_pkg::map_t   old_commit;

  // handshake and stage advance
  assign adv         = s1_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || adv;
  assign in_fire     = req_i.valid && req_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (adv) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  // index range checks
  assign a_ok  = 32'(s1_req_q.arch_reg) < AR;
  assign p_ok  = 32'(s1_req_q.phys_reg) < PR;
  assign a_idx = AIW'(s1_req_q.arch_reg);
  assign p_idx = PIW'(s1_req_q.phys_reg);
  assign old_commit = commit_q[a_idx];

  // lowest free physical register
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = PR - 1; i >= 0; i--) begin
      if (!alloc_q[i]) begin
        free_found = 1'b1;
        free_idx   = PIW'(i);
      end
    end
  end

  // execute one operation
  always_comb begin
    rsp_d     = '0;
    do_alloc  = 1'b0;
    do_wb     = 1'b0;
    do_commit = 1'b0;
    do_free   = 1'b0;
    unique case (rru_pkg::op_e'(s1_req_q.op))
      rru_pkg::OP_ALLOC: begin
        if (a_ok && free_found) begin
          do_alloc       = 1'b1;
          rsp_d.ok       = 1'b1;
          rsp_d.phys_out = rru_pkg::PHYS_W'(free_idx);
        end
      end
      rru_pkg::OP_LOOKUP: begin
        if (a_ok && spec_q[a_idx].valid) begin
          rsp_d.ok       = 1'b1;
          rsp_d.phys_out = rru_pkg::PHYS_W'(spec_q[a_idx].num);
        end
      end
      rru_pkg::OP_READ: begin
        if (p_ok && ready_q[p_idx]) begin
          rsp_d.ok         = 1'b1;
          rsp_d.read_value = values_q[p_idx];
        end
      end
      rru_pkg::OP_WRITEBACK: begin
        if (p_ok) begin
          do_wb    = 1'b1;
          rsp_d.ok = 1'b1;
        end
      end
      rru_pkg::OP_COMMIT: begin
        if (a_ok && p_ok) begin
          do_commit = 1'b1;
          do_free   = old_commit.valid && (old_commit.num != p_idx);
          rsp_d.ok  = 1'b1;
        end
      end
      default: begin
        rsp_d = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_req_q.op          <= req_i.op;
      s1_req_q.arch_reg    <= req_i.arch_reg;
      s1_req_q.phys_reg    <= req_i.phys_reg;
      s1_req_q.write_value <= req_i.write_value;
    end
    if (adv) begin
      rsp_q <= rsp_d;
    end
  end

  // allocation, ready bits and rename tables
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alloc_q <= '0;
      ready_q <= '0;
      for (int i = 0; i < AR; i++) begin
        spec_q[i]   <= '0;
        commit_q[i] <= '0;
      end
    end else if (adv) begin
      if (do_alloc) begin
        alloc_q[free_idx]   <= 1'b1;
        ready_q[free_idx]   <= 1'b0;
        spec_q[a_idx].valid <= 1'b1;
        spec_q[a_idx].num   <= free_idx;
      end
      if (do_wb) begin
        ready_q[p_idx] <= 1'b1;
      end
      if (do_free) begin
        alloc_q[old_commit.num] <= 1'b0;
      end
      if (do_commit) begin
        commit_q[a_idx].valid <= 1'b1;
        commit_q[a_idx].num   <= p_idx;
      end
    end
  end

  // register values
  always_ff @(posedge clk_i) begin
    if (adv && do_wb) begin
      values_q[p_idx] <= s1_req_q.write_value;
    end
  end

  // result channel
  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.ok         = rsp_q.ok;
  assign rsp_o.phys_out   = rsp_q.phys_out;
  assign rsp_o.read_value = rsp_q.read_value;

  // a granted register was free before and is allocated after
  a_alloc_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && do_alloc) |-> (!alloc_q[free_idx] ##1 alloc_q[$past(free_idx)]))
    else $error("allocate did not take a free register");

  // an empty result stage never blocks the input side
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp_valid_q |-> req_i.ready)
    else $error("input stalled with an empty result register");

  // a failed operation reports no register and no value
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !rsp_d.ok) |-> (rsp_d.phys_out == '0 && rsp_d.read_value == '0))
    else $error("failed operation returned data");

endmodule
